>>> design/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared codes, field widths and parameter defaults for the deque core.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int WORD_WIDTH_DEF = 32;

	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 4;
	localparam int STATUS_W = 3;
	localparam int LEN_W    = 5;

	localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
	localparam logic [OP_W-1:0] OP_TAKE   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} deq_state_t;

endpackage

>>> design/double_ended_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of words in a ring memory with put, take, indexed read and
// remove-by-value at either end, driven by a small sequencer.
// ----------------------------------------------------------------------------
// The core holds up to DEPTH words in a ring memory with one write port and
// one registered read port, and works on one request at a time: req_stall is
// high from the cycle after a request is taken until its result has been
// loaded into the response register. A put, and any request that fails on an
// empty or full queue or an index out of range, goes straight to the done
// state; a take or an indexed read first passes the read state for the memory
// read. A remove walks the entries through the single read port and a single
// slot adder, a search read and a compare per entry; a match then alternates
// shift read and shift write per entry moved up to close the gap. The memory
// needs no clearing after reset; only words from written slots are used. A
// waiting response does not block the next request from being taken.
module double_ended_queue_core #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [deq_pkg::OP_W-1:0]      op,
	input  logic                          from_tail,
	input  logic [deq_pkg::VALUE_W-1:0]   value,
	input  logic [deq_pkg::INDEX_W-1:0]   index,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [deq_pkg::VALUE_W-1:0]   word_out,
	output logic [deq_pkg::STATUS_W-1:0]  status,
	output logic [deq_pkg::LEN_W-1:0]     length
);
	import deq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
	localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(DEPTH);

	deq_state_t state_q, state_d;

	logic [WORD_WIDTH-1:0] mem_q [DEPTH];
	logic [WORD_WIDTH-1:0] rd_data_q;

	logic                  tail_q;
	logic [WORD_WIDTH-1:0] val_q;
	logic [PTR_W-1:0]      head_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      j_q;
	logic [PTR_W-1:0]      hit_q;
	logic [WORD_WIDTH-1:0] res_word_q;
	logic [STATUS_W-1:0]   res_status_q;

	logic                  rsp_valid_q;
	logic [VALUE_W-1:0]    word_out_q;
	logic [STATUS_W-1:0]   status_q;
	logic [LEN_W-1:0]      length_q;

	logic                  req_acc;
	logic                  rsp_load;
	logic [WORD_WIDTH-1:0] val_ext;
	logic [CMP_W-1:0]      idx_ext;
	logic [CMP_W-1:0]      cnt_ext;
	logic [CMP_W-1:0]      rd_k;
	logic [CNT_W-1:0]      srch_k;
	logic [CNT_W-1:0]      j_inc;
	logic [PTR_W-1:0]      head_dec;
	logic [PTR_W-1:0]      head_inc;

	// shared slot unit: physical slot of logical position slot_k from the head
	logic [PTR_W-1:0]      slot_k;
	logic [PTR_W:0]        slot_sum;
	logic [PTR_W-1:0]      slot;

	logic                  mem_we;
	logic [PTR_W-1:0]      wr_addr;
	logic [WORD_WIDTH-1:0] wr_data;
	logic [PTR_W-1:0]      rd_addr;

	assign req_acc  = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	assign val_ext  = WORD_WIDTH'(value);
	assign idx_ext  = CMP_W'(index);
	assign cnt_ext  = CMP_W'(count_q);
	assign rd_k     = from_tail ? (cnt_ext - CMP_W'(1) - idx_ext) : idx_ext;
	assign srch_k   = tail_q ? (count_q - CNT_W'(1) - j_q) : j_q;
	assign j_inc    = j_q + CNT_W'(1);
	assign head_dec = (head_q == '0) ? LAST_P : (head_q - PTR_W'(1));
	assign head_inc = (head_q == LAST_P) ? '0 : (head_q + PTR_W'(1));

	assign slot_sum = {1'b0, head_q} + {1'b0, slot_k};
	assign slot     = (slot_sum >= DEPTH_P) ? PTR_W'(slot_sum - DEPTH_P) : slot_sum[PTR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		wr_addr = slot;
		wr_data = rd_data_q;
		rd_addr = slot;
		slot_k  = '0;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					state_d = S_DONE;
					case (op)
						OP_PUT: begin
							slot_k  = count_q[PTR_W-1:0];
							wr_data = val_ext;
							wr_addr = from_tail ? slot : head_dec;
							mem_we  = (count_q != FULL_C);
						end
						OP_TAKE: begin
							slot_k  = PTR_W'(count_q - CNT_W'(1));
							rd_addr = from_tail ? slot : head_q;
							if (count_q != '0) begin
								state_d = S_READ;
							end
						end
						OP_READ: begin
							slot_k = rd_k[PTR_W-1:0];
							if (count_q != '0 && idx_ext < cnt_ext) begin
								state_d = S_READ;
							end
						end
						OP_REMOVE: begin
							if (count_q != '0) begin
								state_d = S_SRCH_RD;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_READ: begin
				state_d = S_DONE;
			end
			S_SRCH_RD: begin
				slot_k  = srch_k[PTR_W-1:0];
				state_d = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (rd_data_q == val_q) begin
					state_d = S_SHIFT_RD;
				end else if (j_inc == count_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SRCH_RD;
				end
			end
			S_SHIFT_RD: begin
				// fetch the word behind the gap, if any is left
				slot_k = j_inc[PTR_W-1:0];
				if (j_inc < count_q) begin
					state_d = S_SHIFT_WR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHIFT_WR: begin
				slot_k  = j_q[PTR_W-1:0];
				mem_we  = 1'b1;
				state_d = S_SHIFT_RD;
			end
			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (op == OP_PUT && count_q != FULL_C) begin
							count_q <= count_q + CNT_W'(1);
							if (!from_tail) begin
								head_q <= head_dec;
							end
						end else if (op == OP_TAKE && count_q != '0) begin
							count_q <= count_q - CNT_W'(1);
							if (!from_tail) begin
								head_q <= head_inc;
							end
						end
					end
				end
				S_SHIFT_RD: begin
					if (!(j_inc < count_q)) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				tail_q       <= from_tail;
				val_q        <= val_ext;
				j_q          <= '0;
				res_word_q   <= '0;
				res_status_q <= STAT_OK;
				case (op)
					OP_PUT: begin
						if (count_q == FULL_C) begin
							res_status_q <= STAT_FULL;
						end
					end
					OP_READ: begin
						if (count_q == '0) begin
							res_status_q <= STAT_EMPTY;
						end else if (!(idx_ext < cnt_ext)) begin
							res_status_q <= STAT_RANGE;
						end
					end
					default: begin
						if (count_q == '0) begin
							res_status_q <= STAT_EMPTY;
						end
					end
				endcase
			end
			S_READ: begin
				res_word_q <= rd_data_q;
			end
			S_SRCH_RD: begin
				hit_q <= srch_k[PTR_W-1:0];
			end
			S_SRCH_CMP: begin
				if (rd_data_q == val_q) begin
					res_word_q <= rd_data_q;
					j_q        <= CNT_W'(hit_q);
				end else begin
					j_q <= j_inc;
					if (j_inc == count_q) begin
						res_status_q <= STAT_NOTFOUND;
					end
				end
			end
			S_SHIFT_WR: begin
				j_q <= j_inc;
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// hold the response payload while it waits; load a new transaction when free
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			word_out_q <= VALUE_W'(res_word_q);
			status_q   <= res_status_q;
			length_q   <= LEN_W'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign word_out  = word_out_q;
	assign status    = status_q;
	assign length    = length_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("entry count exceeds depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST_P)
		else $error("head slot out of range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> req_stall)
		else $error("request taken while previous one still in work");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside completion");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_WR) |-> (j_inc < count_q))
		else $error("compaction walker past last entry");
`endif

endmodule

>>> tb/double_ended_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives put, take, indexed read and remove-by-value requests at both ends,
// first from a short directed table and then at random, with bursty request
// traffic and random and patterned response back-pressure. Each response is
// checked against a behavioral deque held in the testbench, or against the typed expectation of a fixed row.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;
	import deq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1750;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [VALUE_W-1:0]  word;
		logic [STATUS_W-1:0] status;
		logic [LEN_W-1:0]    length;
	} deq_rsp_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic               from_tail;
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
		logic               fixed;
		deq_rsp_t           rsp;
	} deq_row_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PATTERN,
		STALL_HEAVY
	} stall_mode_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic [OP_W-1:0]      op        = OP_PUT;
	logic                 from_tail = 1'b0;
	logic [VALUE_W-1:0]   value     = '0;
	logic [INDEX_W-1:0]   index     = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic [VALUE_W-1:0]   word_out;
	logic [STATUS_W-1:0]  status;
	logic [LEN_W-1:0]     length;

	// typed expectation riding along with the current request
	logic                 req_fixed     = 1'b0;
	deq_rsp_t             req_fixed_rsp = '0;

	// behavioral deque
	logic [VALUE_W-1:0]   ring_mem [DEPTH];
	int                   ring_head  = 0;
	int                   ring_count = 0;

	deq_rsp_t             pending_rsp [$];
	deq_row_t             directed_rows [$];
	int                   fail_count  = 0;
	int unsigned          cycle_count = 0;
	int                   burst_left  = 0;

	stall_mode_t          stall_mode    = STALL_NONE;
	int                   stall_left    = 0;
	logic [7:0]           stall_pattern = '0;

	double_ended_queue_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.op        (op),
		.from_tail (from_tail),
		.value     (value),
		.index     (index),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.word_out  (word_out),
		.status    (status),
		.length    (length)
	);

	always #5 clk = ~clk;

	function automatic int ring_slot(input int pos);
		return (ring_head + pos) % DEPTH;
	endfunction

	// Apply one request to the behavioral deque and return its response.
	function automatic deq_rsp_t deque_apply(input logic [OP_W-1:0] r_op, input logic r_tail,
			input logic [VALUE_W-1:0] r_value, input logic [INDEX_W-1:0] r_index);
		deq_rsp_t r;
		int pos;
		int hit;
		r = '0;
		r.status = STAT_OK;
		case (r_op)
			OP_PUT: begin
				if (ring_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					if (r_tail) begin
						ring_mem[ring_slot(ring_count)] = r_value;
					end else begin
						ring_head = (ring_head + DEPTH - 1) % DEPTH;
						ring_mem[ring_head] = r_value;
					end
					ring_count++;
				end
			end
			OP_TAKE: begin
				if (ring_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					if (r_tail) begin
						r.word = ring_mem[ring_slot(ring_count - 1)];
					end else begin
						r.word = ring_mem[ring_head];
						ring_head = (ring_head + 1) % DEPTH;
					end
					ring_count--;
				end
			end
			OP_READ: begin
				if (ring_count == 0) begin
					r.status = STAT_EMPTY;
				end else if (int'(r_index) >= ring_count) begin
					r.status = STAT_RANGE;
				end else begin
					pos = r_tail ? ring_count - 1 - int'(r_index) : int'(r_index);
					r.word = ring_mem[ring_slot(pos)];
				end
			end
			default: begin
				if (ring_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					hit = -1;
					for (int j = 0; j < ring_count && hit < 0; j++) begin
						pos = r_tail ? ring_count - 1 - j : j;
						if (ring_mem[ring_slot(pos)] == r_value)
							hit = pos;
					end
					if (hit < 0) begin
						r.status = STAT_NOTFOUND;
					end else begin
						r.word = ring_mem[ring_slot(hit)];
						// close the gap toward the head
						for (int j = hit; j + 1 < ring_count; j++)
							ring_mem[ring_slot(j)] = ring_mem[ring_slot(j + 1)];
						ring_count--;
					end
				end
			end
		endcase
		r.length = LEN_W'(ring_count);
		return r;
	endfunction

	task automatic add_row(input logic [OP_W-1:0] r_op, input logic r_tail,
			input logic [VALUE_W-1:0] r_value, input logic [INDEX_W-1:0] r_index,
			input logic r_fixed, input logic [VALUE_W-1:0] r_word,
			input logic [STATUS_W-1:0] r_status, input int r_len);
		deq_row_t row;
		row.op          = r_op;
		row.from_tail   = r_tail;
		row.value       = r_value;
		row.index       = r_index;
		row.fixed       = r_fixed;
		row.rsp.word    = r_word;
		row.rsp.status  = r_status;
		row.rsp.length  = LEN_W'(r_len);
		directed_rows.push_back(row);
	endtask

	// Send one transaction; returns at the edge where it is accepted.
	task automatic send_req(input logic [OP_W-1:0] r_op, input logic r_tail,
			input logic [VALUE_W-1:0] r_value, input logic [INDEX_W-1:0] r_index,
			input logic r_fixed, input deq_rsp_t r_rsp);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		req_valid     <= 1'b1;
		op            <= r_op;
		from_tail     <= r_tail;
		value         <= r_value;
		index         <= r_index;
		req_fixed     <= r_fixed;
		req_fixed_rsp <= r_rsp;
		do @(posedge clk); while (req_stall);
	endtask

	// Predict at request acceptance, check at response acceptance.
	always @(posedge clk) begin : scoreboard
		deq_rsp_t predicted;
		deq_rsp_t oldest;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predicted = deque_apply(op, from_tail, value, index);
				// typed rows still advance the deque above
				if (req_fixed)
					predicted = req_fixed_rsp;
				pending_rsp.push_back(predicted);
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$error("unexpected response: word_out %h status %0d length %0d",
						word_out, status, length);
					fail_count++;
				end else begin
					oldest = pending_rsp.pop_front();
					if (word_out !== oldest.word) begin
						$error("word_out: expected %h, got %h", oldest.word, word_out);
						fail_count++;
					end
					if (status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, status);
						fail_count++;
					end
					if (length !== oldest.length) begin
						$error("length: expected %0d, got %0d", oldest.length, length);
						fail_count++;
					end
				end
			end
		end
	end

	// Response back-pressure: switch to a randomly chosen stall mode after each random run.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode    = stall_mode_t'($urandom_range(0, 3));
			stall_pattern = 8'($urandom);
			stall_left    = $urandom_range(50, 300);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			STALL_NONE:    rsp_stall <= 1'b0;
			STALL_LIGHT:   rsp_stall <= ($urandom_range(0, 2) == 0);
			STALL_PATTERN: rsp_stall <= stall_pattern[cycle_count[2:0]];
			default:       rsp_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("double_ended_queue_core test failed");
		$finish;
	end

	initial begin : stimulus
		logic [VALUE_W-1:0] word_pool [8];
		logic [VALUE_W-1:0] dup;
		logic [OP_W-1:0]    r_op;
		logic [VALUE_W-1:0] r_value;
		int                 roll;
		int                 phase_left;
		logic               fill_bias;

		dup = 32'h0000_BEEF;
		// empty queue
		add_row(OP_TAKE,   1'b0, '0,            4'd0,  1'b1, '0, STAT_EMPTY, 0);
		add_row(OP_READ,   1'b1, '0,            4'd0,  1'b1, '0, STAT_EMPTY, 0);
		add_row(OP_REMOVE, 1'b0, '0,            4'd0,  1'b1, '0, STAT_EMPTY, 0);
		add_row(OP_PUT,    1'b1, 32'hFFFF_FFFF, 4'd15, 1'b1, '0, STAT_OK,    1);
		add_row(OP_PUT,    1'b0, 32'h0000_0000, 4'd0,  1'b1, '0, STAT_OK,    2);
		add_row(OP_REMOVE, 1'b1, 32'h1234_5678, 4'd0,  1'b1, '0, STAT_NOTFOUND, 2);
		// fill to the brim, with repeated words spread through the queue
		add_row(OP_PUT,    1'b0, dup,           4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b1, 32'h0000_0001, 4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b0, 32'h8000_0000, 4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b1, dup,           4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b0, 32'h7FFF_FFFF, 4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b1, 32'h5555_5555, 4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b0, 32'hAAAA_AAAA, 4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b1, dup,           4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b0, 32'h0000_0002, 4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b1, 32'h0000_0003, 4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b0, 32'h0000_0004, 4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b1, 32'h0000_0005, 4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b0, dup,           4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b1, 32'h0000_0006, 4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_PUT,    1'b0, 32'hDEAD_0000, 4'd0,  1'b1, '0, STAT_FULL,  16);
		add_row(OP_READ,   1'b1, '0,            4'd15, 1'b0, '0, STAT_OK, 0);
		add_row(OP_REMOVE, 1'b0, dup,           4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_REMOVE, 1'b1, dup,           4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_READ,   1'b0, '0,            4'd15, 1'b1, '0, STAT_RANGE, 14);
		add_row(OP_TAKE,   1'b0, '0,            4'd0,  1'b0, '0, STAT_OK, 0);
		add_row(OP_TAKE,   1'b1, '0,            4'd0,  1'b0, '0, STAT_OK, 0);

		word_pool[0] = '0;
		word_pool[1] = '1;
		word_pool[2] = dup;
		for (int i = 3; i < 8; i++)
			word_pool[i] = $urandom;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_req(directed_rows[i].op, directed_rows[i].from_tail, directed_rows[i].value,
				directed_rows[i].index, directed_rows[i].fixed, directed_rows[i].rsp);

		// random traffic, swinging between filling and draining the queue
		phase_left = 0;
		fill_bias  = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				fill_bias  = $urandom_range(0, 1);
				phase_left = $urandom_range(20, 60);
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			if (fill_bias)
				r_op = (roll < 50) ? OP_PUT : (roll < 65) ? OP_TAKE :
					(roll < 85) ? OP_READ : OP_REMOVE;
			else
				r_op = (roll < 15) ? OP_PUT : (roll < 55) ? OP_TAKE :
					(roll < 75) ? OP_READ : OP_REMOVE;
			if ($urandom_range(0, 19) == 0)
				word_pool[$urandom_range(0, 7)] = $urandom;
			// draw mostly from a small pool so removes find matches
			r_value = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom) :
				word_pool[$urandom_range(0, 7)];
			send_req(r_op, 1'($urandom_range(0, 1)), r_value, INDEX_W'($urandom_range(0, 15)),
				1'b0, '0);
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		// hold so a stray late response is still caught
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("double_ended_queue_core test passed");
		else
			$display("double_ended_queue_core test failed");
		$finish;
	end

endmodule
